>>> rtl/core/pms_pkg.sv
`timescale 1ns / 1ps

package pms_pkg;

    // Default size of the quarter-wave table: 2^bits + 1 entries.
    localparam int SINE_TABLE_BITS_DEFAULT = 10;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    // pi/2 in Q30.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_START_X       = 3'd0,
        CFG_START_Y       = 3'd1,
        CFG_START_SPEED   = 3'd2,
        CFG_START_HEADING = 3'd3,
        CFG_ACCELERATION  = 3'd4,
        CFG_SPEED_LIMIT   = 3'd5,
        CFG_TURN_RATE     = 3'd6
    } cfg_reg_t;

    // One trig value as read from the table: magnitude in Q0.15 and a sign.
    typedef struct packed {
        logic        neg;
        logic [14:0] mag;
    } trig_t;

    // Quarter-wave entry i: sin(pi/2 * i / 2^bits) by a Taylor series in Q30,
    // rounded half up to Q15 and capped at 32767. Used at elaboration only.
    function automatic logic [14:0] sine_entry(input int unsigned i, input int unsigned bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] q;
        x    = (HALF_PI_Q30 * 64'(i)) >> bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int k = 1; k <= 9; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1)
            begin
                sum = sum - signed'(term);
            end
            else
            begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        q = (sum + 64'sd16384) >>> 15;
        if (q > 64'sd32767)
        begin
            q = 64'sd32767;
        end
        return q[14:0];
    endfunction

endpackage

>>> rtl/core/polar_motion_step.sv
`timescale 1ns / 1ps

// Polar motion step: every item accepted on the slave stream advances one
// moving object by one frame and yields one result item holding the new x and
// y position (Q16.16), speed (Q8.16) and heading (16-bit binary angle). Speed
// first changes by the acceleration and is clamped at the speed limit, the
// heading advances by the turn rate, and the position then moves by speed
// times the cosine and sine of the new heading, wrapping in 32 bits. A set
// reload bit copies the start registers into the state before the step. The
// block takes one item per clock cycle, back to back, unless a held result
// stalls the input, and registers each result; the state loop sets that
// rate, closing the speed clamp, one 24x16 multiply per axis and the position
// add combinationally. Sine and cosine come from two quarter-wave ROMs of
// 2^SINE_TABLE_BITS+1 entries with registered reads, looked up ahead for both
// the continuing and the reloaded heading, so the table never sits in the loop.
// Configuration registers are written through the cfg channel, which is always
// ready, and must only be written while no item is in flight; an index beyond
// the register list is ignored. There is no clearing pass after reset.
module polar_motion_step #(
    parameter int SINE_TABLE_BITS = pms_pkg::SINE_TABLE_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [pms_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // Tick items.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // [0] reload, [7:1] zero
    // Result items.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] x_now, [63:32] y_now, [87:64] speed_now, [103:88] heading_now
    output logic [103:0]                       m_axis_tdata
);

    localparam int TABLE_N       = 1 << SINE_TABLE_BITS;
    localparam int TABLE_ENTRIES = TABLE_N + 1;
    localparam int IDX_BITS      = SINE_TABLE_BITS + 1;
    localparam logic [15:0] QUARTER_TURN = 16'h4000;

    // Configuration registers.
    logic signed [31:0] start_x_reg, start_x_next;
    logic signed [31:0] start_y_reg, start_y_next;
    logic signed [23:0] start_speed_reg, start_speed_next;
    logic        [15:0] start_heading_reg, start_heading_next;
    logic signed [23:0] acceleration_reg, acceleration_next;
    logic signed [23:0] speed_limit_reg, speed_limit_next;
    logic signed [15:0] turn_rate_reg, turn_rate_next;

    // Object state.
    logic signed [31:0] pos_x_reg, pos_x_next;
    logic signed [31:0] pos_y_reg, pos_y_next;
    logic signed [23:0] cur_speed_reg, cur_speed_next;
    logic        [15:0] cur_heading_reg, cur_heading_next;

    // Result register.
    logic               out_valid_reg, out_valid_next;
    logic [103:0]       out_data_reg, out_data_next;

    // Trig of the next heading: "now" continues from the state, "load" starts
    // from the start registers.
    pms_pkg::trig_t     cos_now_reg, sin_now_reg, cos_load_reg, sin_load_reg;

    logic [14:0] rom_now  [TABLE_ENTRIES];
    logic [14:0] rom_load [TABLE_ENTRIES];

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_rom
        assign rom_now[g]  = pms_pkg::sine_entry(g, SINE_TABLE_BITS);
        assign rom_load[g] = pms_pkg::sine_entry(g, SINE_TABLE_BITS);
    end

    function automatic logic [IDX_BITS-1:0] rom_index(input logic [15:0] h);
        logic [IDX_BITS-1:0] fine;
        fine = {1'b0, h[13 -: SINE_TABLE_BITS]};
        return h[14] ? (IDX_BITS'(TABLE_N) - fine) : fine;
    endfunction

    function automatic logic signed [15:0] trig_value(input pms_pkg::trig_t t);
        logic signed [15:0] v;
        v = signed'({1'b0, t.mag});
        return t.neg ? -v : v;
    endfunction

    logic               accept;
    logic               reload;
    logic signed [31:0] base_x, base_y;
    logic signed [23:0] base_speed;
    logic        [15:0] base_heading;
    logic signed [24:0] speed_sum;
    logic signed [24:0] limit_wide;
    logic signed [23:0] speed_new;
    logic        [15:0] heading_new;
    logic signed [15:0] cos_val, sin_val;
    logic signed [39:0] prod_x, prod_y;
    logic signed [39:0] dx_wide, dy_wide;
    logic        [15:0] look_now_h, look_load_h;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign reload        = s_axis_tdata[0];
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        start_x_next       = start_x_reg;
        start_y_next       = start_y_reg;
        start_speed_next   = start_speed_reg;
        start_heading_next = start_heading_reg;
        acceleration_next  = acceleration_reg;
        speed_limit_next   = speed_limit_reg;
        turn_rate_next     = turn_rate_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                pms_pkg::CFG_START_X:       start_x_next       = signed'(cfg_data);
                pms_pkg::CFG_START_Y:       start_y_next       = signed'(cfg_data);
                pms_pkg::CFG_START_SPEED:   start_speed_next   = signed'(cfg_data[23:0]);
                pms_pkg::CFG_START_HEADING: start_heading_next = cfg_data[15:0];
                pms_pkg::CFG_ACCELERATION:  acceleration_next  = signed'(cfg_data[23:0]);
                pms_pkg::CFG_SPEED_LIMIT:   speed_limit_next   = signed'(cfg_data[23:0]);
                pms_pkg::CFG_TURN_RATE:     turn_rate_next     = signed'(cfg_data[15:0]);
                default:                    ;
            endcase
        end
    end

    // One frame of motion.
    always_comb
    begin
        base_x       = reload ? start_x_reg       : pos_x_reg;
        base_y       = reload ? start_y_reg       : pos_y_reg;
        base_speed   = reload ? start_speed_reg   : cur_speed_reg;
        base_heading = reload ? start_heading_reg : cur_heading_reg;

        // The clamped speed always fits 24 bits, so truncation is safe.
        speed_sum  = 25'(base_speed) + 25'(acceleration_reg);
        limit_wide = 25'(speed_limit_reg);
        speed_new  = base_speed;
        if (acceleration_reg != 24'sd0)
        begin
            if (!acceleration_reg[23] && (speed_sum > limit_wide))
            begin
                speed_new = speed_limit_reg;
            end
            else if (acceleration_reg[23] && (speed_sum < limit_wide))
            begin
                speed_new = speed_limit_reg;
            end
            else
            begin
                speed_new = speed_sum[23:0];
            end
        end

        heading_new = base_heading + 16'(turn_rate_reg);

        cos_val = reload ? trig_value(cos_load_reg) : trig_value(cos_now_reg);
        sin_val = reload ? trig_value(sin_load_reg) : trig_value(sin_now_reg);

        // Rounded floor division by 2^15 is an arithmetic shift.
        prod_x  = 40'(speed_new) * 40'(cos_val);
        prod_y  = 40'(speed_new) * 40'(sin_val);
        dx_wide = (prod_x + 40'sd16384) >>> 15;
        dy_wide = (prod_y + 40'sd16384) >>> 15;

        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        cur_speed_next   = cur_speed_reg;
        cur_heading_next = cur_heading_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_data_next    = out_data_reg;
        if (accept)
        begin
            pos_x_next       = base_x + dx_wide[31:0];
            pos_y_next       = base_y + dy_wide[31:0];
            cur_speed_next   = speed_new;
            cur_heading_next = heading_new;
            out_valid_next   = 1'b1;
            out_data_next    = {heading_new, speed_new, pos_y_next, pos_x_next};
        end

        // Headings the next item will use, from the values the registers take.
        look_now_h  = cur_heading_next + 16'(turn_rate_next);
        look_load_h = start_heading_next + 16'(turn_rate_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            start_speed_reg   <= '0;
            start_heading_reg <= '0;
            acceleration_reg  <= '0;
            speed_limit_reg   <= '0;
            turn_rate_reg     <= '0;
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            cur_speed_reg     <= '0;
            cur_heading_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            start_x_reg       <= start_x_next;
            start_y_reg       <= start_y_next;
            start_speed_reg   <= start_speed_next;
            start_heading_reg <= start_heading_next;
            acceleration_reg  <= acceleration_next;
            speed_limit_reg   <= speed_limit_next;
            turn_rate_reg     <= turn_rate_next;
            pos_x_reg         <= pos_x_next;
            pos_y_reg         <= pos_y_next;
            cur_speed_reg     <= cur_speed_next;
            cur_heading_reg   <= cur_heading_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // Table reads are registered ahead. Reset leaves the trig of heading zero,
    // which matches the reset state and the reset registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_now_reg  <= '{neg: 1'b0, mag: pms_pkg::sine_entry(TABLE_N, SINE_TABLE_BITS)};
            sin_now_reg  <= '{neg: 1'b0, mag: pms_pkg::sine_entry(0, SINE_TABLE_BITS)};
            cos_load_reg <= '{neg: 1'b0, mag: pms_pkg::sine_entry(TABLE_N, SINE_TABLE_BITS)};
            sin_load_reg <= '{neg: 1'b0, mag: pms_pkg::sine_entry(0, SINE_TABLE_BITS)};
        end
        else
        begin
            cos_now_reg.neg  <= look_now_h[15] ^ look_now_h[14];
            cos_now_reg.mag  <= rom_now[rom_index(look_now_h + QUARTER_TURN)];
            sin_now_reg.neg  <= look_now_h[15];
            sin_now_reg.mag  <= rom_now[rom_index(look_now_h)];
            cos_load_reg.neg <= look_load_h[15] ^ look_load_h[14];
            cos_load_reg.mag <= rom_load[rom_index(look_load_h + QUARTER_TURN)];
            sin_load_reg.neg <= look_load_h[15];
            sin_load_reg.mag <= rom_load[rom_index(look_load_h)];
        end
    end

endmodule

>>> test/polar_motion_step_tb.sv
`timescale 1ns / 1ps

module testbench;

    localparam int TABLE_BITS = pms_pkg::SINE_TABLE_BITS_DEFAULT;
    localparam int TABLE_SIZE = (1 << TABLE_BITS) + 1;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    // Index 7 is past the end of the register list and must be ignored.
    localparam logic [pms_pkg::CFG_INDEX_BITS-1:0] UNUSED_INDEX = 3'd7;

    // Pacing of the run.
    localparam int MAX_GAP          = 12;
    localparam int QUIET_STRETCH    = 40;
    localparam int SETTLE_CYCLES    = 4;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int FIRST_HOLD_AT    = 200;
    localparam int SECOND_HOLD_AT   = 450;
    localparam int STALL_LIMIT      = 3000;
    localparam int RANDOM_PHASES    = 10;
    localparam int TICKS_PER_PHASE  = 63;
    localparam int RELOAD_PERCENT   = 8;

    // One frame of object state, laid out like the result item.
    typedef struct packed {
        logic [15:0] heading;
        logic [23:0] speed;
        logic [31:0] y;
        logic [31:0] x;
    } frame_t;

    // A full register setting. Fields are carried at the width of the write
    // channel, so bits above a register's width may hold junk on purpose.
    typedef struct packed {
        logic [31:0] start_x;
        logic [31:0] start_y;
        logic [31:0] start_speed;
        logic [31:0] start_heading;
        logic [31:0] acceleration;
        logic [31:0] speed_limit;
        logic [31:0] turn_rate;
    } motion_setting_t;

    // Keeps its own copy of the registers and the object state, predicts the
    // frame that each accepted tick produces and checks result items in order.
    class motion_scoreboard;
        logic [31:0] start_x;
        logic [31:0] start_y;
        logic [23:0] start_speed;
        logic [15:0] start_heading;
        logic [23:0] acceleration;
        logic [23:0] speed_limit;
        logic [15:0] turn_rate;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [23:0] cur_speed;
        logic [15:0] cur_heading;
        int          quarter_wave[TABLE_SIZE];
        frame_t      expected_frames[$];
        int          error_count;
        int          frame_count;

        // Quarter-wave sine in Q1.15 from a Taylor series evaluated in Q30.
        function new();
            longint unsigned point;
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint unsigned divisor;
            longint          sum;
            longint          q;
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                point = i;
                x     = (PI_HALF_Q30 * point) >> TABLE_BITS;
                x2    = (x * x) >> 30;
                term  = x;
                sum   = x;
                for (int k = 1; k <= 9; k++)
                begin
                    divisor = (2 * k) * (2 * k + 1);
                    term    = ((term * x2) >> 30) / divisor;
                    if (k % 2 == 1)
                    begin
                        sum = sum - longint'(term);
                    end
                    else
                    begin
                        sum = sum + longint'(term);
                    end
                end
                if (sum < 0)
                begin
                    sum = 0;
                end
                q = (sum + 16384) >>> 15;
                if (q > 32767)
                begin
                    q = 32767;
                end
                quarter_wave[i] = int'(q);
            end
            start_x       = '0;
            start_y       = '0;
            start_speed   = '0;
            start_heading = '0;
            acceleration  = '0;
            speed_limit   = '0;
            turn_rate     = '0;
            pos_x         = '0;
            pos_y         = '0;
            cur_speed     = '0;
            cur_heading   = '0;
            error_count   = 0;
            frame_count   = 0;
        endfunction

        function void write_register(logic [pms_pkg::CFG_INDEX_BITS-1:0] index,
                                     logic [31:0] value);
            case (index)
                pms_pkg::CFG_START_X:       start_x       = value;
                pms_pkg::CFG_START_Y:       start_y       = value;
                pms_pkg::CFG_START_SPEED:   start_speed   = value[23:0];
                pms_pkg::CFG_START_HEADING: start_heading = value[15:0];
                pms_pkg::CFG_ACCELERATION:  acceleration  = value[23:0];
                pms_pkg::CFG_SPEED_LIMIT:   speed_limit   = value[23:0];
                pms_pkg::CFG_TURN_RATE:     turn_rate     = value[15:0];
                default:                    ;
            endcase
        endfunction

        // Quadrants mirror and negate the quarter-wave table.
        function int sine_of(logic [15:0] angle);
            int idx;
            int mag;
            idx = int'(angle[13:0]) >> (14 - TABLE_BITS);
            mag = angle[14] ? quarter_wave[(1 << TABLE_BITS) - idx] : quarter_wave[idx];
            return angle[15] ? -mag : mag;
        endfunction

        function frame_t advance_frame(bit reload);
            longint spd;
            longint acc;
            longint lim;
            longint cosine;
            longint sine;
            longint dx;
            longint dy;
            frame_t next;
            if (reload)
            begin
                pos_x       = start_x;
                pos_y       = start_y;
                cur_speed   = start_speed;
                cur_heading = start_heading;
            end
            spd = signed'(cur_speed);
            acc = signed'(acceleration);
            lim = signed'(speed_limit);
            // The clamp applies even when speed already sits past the limit.
            if (acc != 0)
            begin
                spd = spd + acc;
                if (acc > 0 && spd > lim)
                begin
                    spd = lim;
                end
                if (acc < 0 && spd < lim)
                begin
                    spd = lim;
                end
            end
            cur_speed   = spd[23:0];
            cur_heading = cur_heading + turn_rate;
            cosine      = sine_of(cur_heading + 16'h4000);
            sine        = sine_of(cur_heading);
            // Arithmetic shift gives the floor of the rounded quotient.
            dx          = (spd * cosine + 16384) >>> 15;
            dy          = (spd * sine + 16384) >>> 15;
            pos_x       = pos_x + dx[31:0];
            pos_y       = pos_y + dy[31:0];
            next.x       = pos_x;
            next.y       = pos_y;
            next.speed   = cur_speed;
            next.heading = cur_heading;
            return next;
        endfunction

        function void note_tick(bit reload);
            expected_frames = {expected_frames, advance_frame(reload)};
        endfunction

        task report_mismatch(string msg);
            $display("ERROR at result %0d: %s", frame_count, msg);
            error_count++;
        endtask

        task check_result(logic [103:0] data);
            frame_t want;
            if (expected_frames.size() == 0)
            begin
                report_mismatch($sformatf("result item %h with no tick waiting", data));
                return;
            end
            want = expected_frames[0];
            expected_frames.delete(0);
            if (data[31:0] !== want.x)
            begin
                report_mismatch($sformatf("x_now %h, expected %h", data[31:0], want.x));
            end
            if (data[63:32] !== want.y)
            begin
                report_mismatch($sformatf("y_now %h, expected %h", data[63:32], want.y));
            end
            if (data[87:64] !== want.speed)
            begin
                report_mismatch($sformatf("speed_now %h, expected %h",
                                          data[87:64], want.speed));
            end
            if (data[103:88] !== want.heading)
            begin
                report_mismatch($sformatf("heading_now %h, expected %h",
                                          data[103:88], want.heading));
            end
            frame_count++;
        endtask
    endclass

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [pms_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [pms_pkg::CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [7:0]                         s_axis_tdata = '0;   // [0] reload, [7:1] zero
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    // [31:0] x_now, [63:32] y_now, [87:64] speed_now, [103:88] heading_now
    logic [103:0]                       m_axis_tdata;

    motion_scoreboard scoreboard;
    int               ticks_sent = 0;
    bit               send_quiet = 1'b0;

    polar_motion_step #(
        .SINE_TABLE_BITS(TABLE_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Writes one register and leaves cfg_valid high, so that a run of writes
    // never lowers and raises it within one time step. The caller lowers it.
    task automatic write_register(logic [pms_pkg::CFG_INDEX_BITS-1:0] index,
                                  logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        scoreboard.write_register(index, value);
    endtask

    // Writes the whole register set, plus one write to the unused index that
    // the block must drop without touching any register.
    task automatic program_registers(motion_setting_t setting);
        write_register(pms_pkg::CFG_START_X, setting.start_x);
        write_register(pms_pkg::CFG_START_Y, setting.start_y);
        write_register(pms_pkg::CFG_START_SPEED, setting.start_speed);
        write_register(pms_pkg::CFG_START_HEADING, setting.start_heading);
        write_register(pms_pkg::CFG_ACCELERATION, setting.acceleration);
        write_register(pms_pkg::CFG_SPEED_LIMIT, setting.speed_limit);
        write_register(pms_pkg::CFG_TURN_RATE, setting.turn_rate);
        write_register(UNUSED_INDEX, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // Offers one tick item after an idle gap and waits until it is taken. The
    // valid stays high when the next item follows with no gap.
    task automatic send_tick(logic [7:0] item);
        int gap;
        if (ticks_sent % QUIET_STRETCH == 0)
        begin
            send_quiet = ($urandom_range(0, 2) == 0);
        end
        gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        do @(posedge clk); while (!s_axis_tready);
        scoreboard.note_tick(item[0]);
        ticks_sent++;
    endtask

    // Configuration may only change with nothing in flight: wait for every
    // expected frame, then give the pipeline time to empty.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (scoreboard.expected_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register value biased toward the extremes of its width, with random junk
    // above the width that the block has to discard.
    function automatic logic [31:0] draw_value(int width);
        logic [31:0] mask;
        logic [31:0] value;
        mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'h1 << width) - 32'h1);
        case ($urandom_range(0, 7))
            0:       value = '0;
            1:       value = 32'hFFFF_FFFF;
            2:       value = 32'h1 << (width - 1);
            3:       value = (32'h1 << (width - 1)) - 32'h1;
            4, 5:    value = $urandom_range(0, 2000) - 1000;
            default: value = $urandom;
        endcase
        return (value & mask) | ($urandom & ~mask);
    endfunction

    function automatic motion_setting_t draw_setting();
        motion_setting_t setting;
        setting.start_x       = draw_value(32);
        setting.start_y       = draw_value(32);
        setting.start_speed   = draw_value(24);
        setting.start_heading = draw_value(16);
        setting.acceleration  = draw_value(24);
        setting.speed_limit   = draw_value(24);
        setting.turn_rate     = draw_value(16);
        return setting;
    endfunction

    // Receiver: idles a random number of cycles before each result, with quiet
    // stretches, and twice holds off for a long stretch while ticks keep coming
    // so that the result register fills and the input stalls.
    initial
    begin
        int gap;
        int taken;
        bit quiet;
        taken = 0;
        quiet = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % QUIET_STRETCH == 0)
            begin
                quiet = ($urandom_range(0, 2) == 0);
            end
            gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (taken == FIRST_HOLD_AT || taken == SECOND_HOLD_AT)
            begin
                gap = LONG_HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            scoreboard.check_result(m_axis_tdata);
            taken++;
        end
    end

    // Watchdog: any handshake on any channel counts as progress. A long run of
    // cycles without one means the block has hung.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Main sequence: directed phases first, then random register settings,
    // each followed by a stream of tick items.
    initial
    begin
        motion_setting_t setting;
        bit              reload;
        logic [6:0]      pad;
        scoreboard = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight out of reset: every register and the state are zero.
        send_tick(8'h00);
        send_tick(8'h00);
        wait_idle();

        // Position wrap in x, both ways, at full speed with zero acceleration; the
        // nonzero limit must be ignored. Some ticks carry junk above the
        // reload bit.
        setting.start_x       = 32'h7FFF_FFFF;
        setting.start_y       = 32'h8000_0000;
        setting.start_speed   = 32'h007F_FFFF;
        setting.start_heading = 32'h0000_C000;
        setting.acceleration  = 32'h0000_0000;
        setting.speed_limit   = 32'h0012_3456;
        setting.turn_rate     = 32'h0000_4000;
        program_registers(setting);
        send_tick(8'hFF);
        send_tick(8'h00);
        send_tick(8'hFE);
        send_tick(8'h00);
        send_tick(8'h00);
        wait_idle();

        // Largest positive acceleration against the largest limit, fastest
        // positive turn.
        setting.start_x       = 32'h0000_0000;
        setting.start_y       = 32'h0000_0000;
        setting.start_speed   = 32'h007F_FFFF;
        setting.start_heading = 32'h0000_2000;
        setting.acceleration  = 32'h007F_FFFF;
        setting.speed_limit   = 32'h007F_FFFF;
        setting.turn_rate     = 32'h0000_7FFF;
        program_registers(setting);
        send_tick(8'h01);
        send_tick(8'h00);
        send_tick(8'h00);
        wait_idle();

        // Speed far above a negative limit with a small positive acceleration:
        // the clamp pulls it down to the limit in one frame.
        setting.start_speed   = 32'h000F_4240;
        setting.start_heading = 32'h0000_A000;
        setting.acceleration  = 32'h0000_0001;
        setting.speed_limit   = 32'hFFFF_FE0C;
        setting.turn_rate     = 32'h0000_0100;
        program_registers(setting);
        send_tick(8'h01);
        send_tick(8'h00);
        send_tick(8'h00);
        wait_idle();

        // Most negative acceleration, limit and speed; turn rate at its most
        // negative; heading starts at the largest angle.
        setting.start_x       = 32'h8000_0000;
        setting.start_y       = 32'h7FFF_FFFF;
        setting.start_speed   = 32'h0080_0000;
        setting.start_heading = 32'h0000_FFFF;
        setting.acceleration  = 32'h0080_0000;
        setting.speed_limit   = 32'h0080_0000;
        setting.turn_rate     = 32'h0000_8000;
        program_registers(setting);
        send_tick(8'h01);
        send_tick(8'h00);
        send_tick(8'h00);
        wait_idle();

        // Speed below a positive limit with a negative acceleration: it jumps
        // up to the limit at once.
        setting.start_x       = 32'h0000_0000;
        setting.start_y       = 32'h0000_0000;
        setting.start_speed   = 32'hFFFF_EC78;
        setting.start_heading = 32'h0000_6000;
        setting.acceleration  = 32'hFFFF_FFFF;
        setting.speed_limit   = 32'h0000_0064;
        setting.turn_rate     = 32'h0000_0001;
        program_registers(setting);
        send_tick(8'h01);
        send_tick(8'h00);
        send_tick(8'h00);
        wait_idle();

        // Random settings, each with a long stream of ticks. Most phases begin
        // with a reload; reloads also land at random inside the stream.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            program_registers(draw_setting());
            for (int n = 0; n < TICKS_PER_PHASE; n++)
            begin
                if (n == 0)
                begin
                    reload = ($urandom_range(0, 3) != 0);
                end
                else
                begin
                    reload = ($urandom_range(0, 99) < RELOAD_PERCENT);
                end
                pad = ($urandom_range(0, 15) == 0) ? 7'($urandom) : 7'd0;
                send_tick({pad, reload});
            end
            wait_idle();
        end

        if (scoreboard.expected_frames.size() != 0)
        begin
            scoreboard.report_mismatch($sformatf("%0d expected frames never arrived",
                                                 scoreboard.expected_frames.size()));
        end
        if (scoreboard.error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> polar_motion_step.f
rtl/core/pms_pkg.sv
rtl/core/polar_motion_step.sv
test/polar_motion_step_tb.sv
